[rtl/wvtt_pkg.sv]
// shared types and constants for the streaming webvtt timestamp parser
// no dependencies; used by the interfaces, the parser core and the top level
package wvtt_pkg;

  localparam int HOUR_BITS_DEF = 20;
  localparam int CHAR_W        = 8;
  localparam int TIME_W        = 42;
  localparam int USED_W        = 8;
  localparam int FRAC_W        = 10;
  localparam int SEXA_W        = 6;

  localparam int MS_PER_HOUR   = 3600000;
  localparam int MS_HOUR_W     = 22;
  localparam int MS_PER_MIN    = 60000;
  localparam int MS_PER_SEC    = 1000;
  // minutes, seconds and fraction together stay below one hour of milliseconds
  localparam int MSF_W         = 22;

  // result request handed from the parser core to the time pipeline
  typedef struct packed {
    logic              emit;
    logic              ok;
    logic [SEXA_W-1:0] mins;
    logic [SEXA_W-1:0] secs;
    logic [FRAC_W-1:0] frac;
    logic [USED_W-1:0] used;
  } res_t;

endpackage

[rtl/wvtt_in_if.sv]
// character channel: valid/ready handshake carrying one text character
// depends on wvtt_pkg
interface wvtt_in_if import wvtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              start_req;
  logic [CHAR_W-1:0] ch;
  logic              last;

  modport source (output valid, output start_req, output ch, output last, input ready);
  modport sink   (input valid, input start_req, input ch, input last, output ready);
endinterface

[rtl/wvtt_out_if.sv]
// result channel: valid/ready handshake carrying one parsed timestamp
// depends on wvtt_pkg
interface wvtt_out_if import wvtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [TIME_W-1:0] time_ms;
  logic [USED_W-1:0] chars_used;

  modport source (output valid, output valid_res, output time_ms, output chars_used,
                  input ready);
  modport sink   (input valid, input valid_res, input time_ms, input chars_used,
                  output ready);
endinterface

[rtl/webvtt_timestamp_parser.sv]
// webvtt timestamp parser top level: parser core plus a three-register time pipeline
// a result passes registers s1, s2 and out after the transfer of the character deciding it
// throughput: one character per cycle while ready is high; hours multiply shares stage s2
// stages advance independently, so a stalled result does not block an empty pipeline
// reset: synchronous rst returns the parser to idle and empties every stage
// depends on wvtt_pkg, wvtt_in_if, wvtt_out_if and wvtt_parse
module webvtt_timestamp_parser import wvtt_pkg::*; #(
  parameter int HOUR_BITS = HOUR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wvtt_in_if.sink     char_in,
  wvtt_out_if.source  res_out
);

  localparam int PROD_W = HOUR_BITS + MS_HOUR_W;

  res_t                 pres;
  logic [HOUR_BITS-1:0] phours;
  logic                 take;

  logic                 s1_valid;
  res_t                 s1_res;
  logic [HOUR_BITS-1:0] s1_hours;

  logic                 s2_valid;
  logic                 s2_ok;
  logic [USED_W-1:0]    s2_used;
  logic [PROD_W-1:0]    s2_hprod;
  logic [MSF_W-1:0]     s2_msf;

  logic                 out_valid;
  logic                 out_ok;
  logic [TIME_W-1:0]    out_time;
  logic [USED_W-1:0]    out_used;

  logic                 load1, load2, load3;

  assign load3 = !out_valid || res_out.ready;
  assign load2 = !s2_valid || load3;
  assign load1 = !s1_valid || load2;
  assign char_in.ready = load1;
  assign take = char_in.valid && load1;

  wvtt_parse #(.HOUR_BITS(HOUR_BITS)) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .start_req (char_in.start_req),
    .ch        (char_in.ch),
    .last      (char_in.last),
    .res       (pres),
    .hours     (phours)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load1) s1_valid <= take && pres.emit;
      if (load2) s2_valid <= s1_valid;
      if (load3) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      s1_res   <= pres;
      s1_hours <= phours;
    end
    if (load2) begin
      s2_ok    <= s1_res.ok;
      s2_used  <= s1_res.used;
      s2_hprod <= PROD_W'(s1_hours) * PROD_W'(MS_PER_HOUR);
      s2_msf   <= MSF_W'(s1_res.mins) * MSF_W'(MS_PER_MIN)
                + MSF_W'(s1_res.secs) * MSF_W'(MS_PER_SEC)
                + MSF_W'(s1_res.frac);
    end
    if (load3) begin
      out_ok   <= s2_ok;
      out_used <= s2_used;
      out_time <= TIME_W'(s2_hprod) + TIME_W'(s2_msf);
    end
  end

  assign res_out.valid      = out_valid;
  assign res_out.valid_res  = out_ok;
  assign res_out.time_ms    = out_time;
  assign res_out.chars_used = out_used;

  // a malformed parse carries no time into the pipeline
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ok |-> s2_hprod == '0 && s2_msf == '0)
    else $error("malformed result carries nonzero time");

  // a well formed timestamp needs at least mm:ss.ttt
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ok |-> out_used >= USED_W'(9))
    else $error("valid result with too few characters");

  // input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !char_in.ready |-> s1_valid && s2_valid && out_valid && !res_out.ready)
    else $error("input stalled with room in the pipeline");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s1_valid && !s2_valid && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

[rtl/wvtt_parse.sv]
// parser core: phase machine and digit-group accumulators, one character per transfer
// depends on wvtt_pkg; produces a result request for the time pipeline
module wvtt_parse import wvtt_pkg::*; #(
  parameter int HOUR_BITS = HOUR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 start_req,
  input  logic [CHAR_W-1:0]    ch,
  input  logic                 last,
  output res_t                 res,
  output logic [HOUR_BITS-1:0] hours
);

  typedef enum logic [7:0] {
    PH_IDLE     = 8'b0000_0001,
    PH_G1       = 8'b0000_0010,
    PH_G2_FIRST = 8'b0000_0100,
    PH_G2       = 8'b0000_1000,
    PH_G3_FIRST = 8'b0001_0000,
    PH_G3       = 8'b0010_0000,
    PH_FR_FIRST = 8'b0100_0000,
    PH_FR       = 8'b1000_0000
  } phase_t;

  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CH_NINE  = CHAR_W'(8'h39);
  localparam logic [CHAR_W-1:0] CH_COLON = CHAR_W'(8'h3a);
  localparam logic [CHAR_W-1:0] CH_DOT   = CHAR_W'(8'h2e);
  localparam logic [HOUR_BITS-1:0] HMAX  = {HOUR_BITS{1'b1}};
  localparam int HW = HOUR_BITS + 4;
  localparam logic [FRAC_W-1:0] SAT7     = 10'd127;
  localparam logic [FRAC_W-1:0] SAT10    = 10'd1023;
  localparam logic [6:0] MAX_SEXA        = 7'd59;

  // decimal accumulate with saturation at maxv
  function automatic logic [FRAC_W-1:0] acc_dec(input logic [FRAC_W-1:0] acc,
                                                input logic [3:0] d,
                                                input logic [FRAC_W-1:0] maxv);
    logic [FRAC_W+3:0] n;
    n = {4'b0, acc} * 14'd10 + {10'b0, d};
    return (n > {4'b0, maxv}) ? maxv : n[FRAC_W-1:0];
  endfunction

  phase_t               phase, phase_next;
  logic [7:0]           group_digits, group_digits_next;
  logic [HOUR_BITS-1:0] first_group, first_group_next;
  logic [6:0]           second_group, second_group_next;
  logic [6:0]           third_group, third_group_next;
  logic [FRAC_W-1:0]    fraction_value, fraction_value_next;
  logic                 hours_mode, hours_mode_next;
  logic [USED_W-1:0]    used_count, used_count_next;

  logic                 dig;
  logic [3:0]           d;
  logic [HW-1:0]        fg_wide;
  logic [HOUR_BITS-1:0] fg_acc;
  logic [7:0]           gd_inc;
  logic [USED_W-1:0]    uc_inc;
  logic                 fail, fin;
  logic                 m_over, s_over, ok;

  assign dig     = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign d       = dig ? 4'(ch - CH_ZERO) : 4'd0;
  assign fg_wide = HW'(first_group) * HW'(10) + HW'(d);
  assign fg_acc  = (fg_wide > HW'(HMAX)) ? HMAX : fg_wide[HOUR_BITS-1:0];
  assign gd_inc  = (group_digits == 8'hff) ? group_digits : group_digits + 8'd1;
  assign uc_inc  = (used_count == {USED_W{1'b1}}) ? used_count : used_count + USED_W'(1);

  always_comb begin
    phase_next          = phase;
    group_digits_next   = group_digits;
    first_group_next    = first_group;
    second_group_next   = second_group;
    third_group_next    = third_group;
    fraction_value_next = fraction_value;
    hours_mode_next     = hours_mode;
    used_count_next     = used_count;
    fail                = 1'b0;
    fin                 = 1'b0;
    if (start_req) begin
      phase_next          = PH_IDLE;
      group_digits_next   = 8'd0;
      first_group_next    = '0;
      second_group_next   = '0;
      third_group_next    = '0;
      fraction_value_next = '0;
      hours_mode_next     = 1'b0;
      used_count_next     = '0;
      if (!dig) begin
        fail = 1'b1;
      end else begin
        first_group_next  = HOUR_BITS'(d);
        group_digits_next = 8'd1;
        used_count_next   = USED_W'(1);
        phase_next        = PH_G1;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_G1: begin
          if (dig) begin
            first_group_next  = fg_acc;
            group_digits_next = gd_inc;
            used_count_next   = uc_inc;
          end else begin
            hours_mode_next = (group_digits != 8'd2) || (first_group > HOUR_BITS'(MAX_SEXA));
            used_count_next = uc_inc;
            if (ch != CH_COLON) fail = 1'b1;
            else phase_next = PH_G2_FIRST;
          end
        end
        PH_G2_FIRST: begin
          if (!dig) begin
            fail = 1'b1;
          end else begin
            second_group_next = 7'(d);
            group_digits_next = 8'd1;
            used_count_next   = uc_inc;
            phase_next        = PH_G2;
          end
        end
        PH_G2: begin
          if (dig) begin
            second_group_next = 7'(acc_dec(10'(second_group), d, SAT7));
            group_digits_next = gd_inc;
            used_count_next   = uc_inc;
          end else if (group_digits != 8'd2) begin
            fail = 1'b1;
          end else begin
            used_count_next = uc_inc;
            if (ch == CH_COLON) begin
              hours_mode_next = 1'b1;
              phase_next      = PH_G3_FIRST;
            end else if (!hours_mode && ch == CH_DOT) begin
              phase_next = PH_FR_FIRST;
            end else begin
              fail = 1'b1;
            end
          end
        end
        PH_G3_FIRST: begin
          if (!dig) begin
            fail = 1'b1;
          end else begin
            third_group_next  = 7'(d);
            group_digits_next = 8'd1;
            used_count_next   = uc_inc;
            phase_next        = PH_G3;
          end
        end
        PH_G3: begin
          if (dig) begin
            third_group_next  = 7'(acc_dec(10'(third_group), d, SAT7));
            group_digits_next = gd_inc;
            used_count_next   = uc_inc;
          end else if (group_digits != 8'd2) begin
            fail = 1'b1;
          end else begin
            used_count_next = uc_inc;
            if (ch != CH_DOT) fail = 1'b1;
            else phase_next = PH_FR_FIRST;
          end
        end
        PH_FR_FIRST: begin
          if (!dig) begin
            fail = 1'b1;
          end else begin
            fraction_value_next = FRAC_W'(d);
            group_digits_next   = 8'd1;
            used_count_next     = uc_inc;
            phase_next          = PH_FR;
          end
        end
        PH_FR: begin
          if (!dig) begin
            fin = 1'b1;
          end else begin
            fraction_value_next = acc_dec(fraction_value, d, SAT10);
            group_digits_next   = gd_inc;
            used_count_next     = uc_inc;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    // end of text closes any open parse
    if (!fail && !fin && last && phase_next != PH_IDLE) begin
      if (phase_next == PH_FR) fin = 1'b1;
      else fail = 1'b1;
    end
  end

  // judge the finished parse on the updated groups
  always_comb begin
    m_over = hours_mode_next ? (second_group_next > MAX_SEXA)
                             : (first_group_next > HOUR_BITS'(MAX_SEXA));
    s_over = hours_mode_next ? (third_group_next > MAX_SEXA)
                             : (second_group_next > MAX_SEXA);
    ok     = fin && (group_digits_next == 8'd3) && !m_over && !s_over;
    res.emit = fail || fin;
    res.ok   = ok;
    res.used = used_count_next;
    res.mins = !ok ? '0 : (hours_mode_next ? second_group_next[SEXA_W-1:0]
                                           : first_group_next[SEXA_W-1:0]);
    res.secs = !ok ? '0 : (hours_mode_next ? third_group_next[SEXA_W-1:0]
                                           : second_group_next[SEXA_W-1:0]);
    res.frac = ok ? fraction_value_next : '0;
    hours    = (ok && hours_mode_next) ? first_group_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      group_digits   <= 8'd0;
      first_group    <= '0;
      second_group   <= '0;
      third_group    <= '0;
      fraction_value <= '0;
      hours_mode     <= 1'b0;
      used_count     <= '0;
    end else if (take) begin
      phase          <= res.emit ? PH_IDLE : phase_next;
      group_digits   <= group_digits_next;
      first_group    <= first_group_next;
      second_group   <= second_group_next;
      third_group    <= third_group_next;
      fraction_value <= fraction_value_next;
      hours_mode     <= hours_mode_next;
      used_count     <= used_count_next;
    end
  end

endmodule

[dv/webvtt_timestamp_parser_tb.sv]
// self-checking testbench for webvtt_timestamp_parser: a character stream goes in, the
// expected timestamp results are worked out per transfer and compared as they come out
// depends on wvtt_pkg, wvtt_in_if, wvtt_out_if and the webvtt_timestamp_parser rtl
module webvtt_timestamp_parser_tb;
  import wvtt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOURS_W         = HOUR_BITS_DEF;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 10;
  localparam int RANDOM_CHARS    = 300;

  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    P_IDLE, P_G1, P_G2_LEAD, P_G2, P_G3_LEAD, P_G3, P_FR_LEAD, P_FR
  } parse_phase_t;

  typedef struct packed {
    logic              ok;
    logic [TIME_W-1:0] ms;
    logic [USED_W-1:0] used;
  } stamp_t;

  logic clk;
  logic rst;

  wvtt_in_if  char_if ();
  wvtt_out_if res_if ();

  webvtt_timestamp_parser #(.HOUR_BITS(HOURS_W)) dut (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_if),
    .res_out (res_if)
  );

  // predictor state
  parse_phase_t       ph;
  logic [7:0]         ndig;
  logic [HOURS_W-1:0] grp1;
  logic [6:0]         grp2;
  logic [6:0]         grp3;
  logic [FRAC_W-1:0]  frac;
  logic               hrs;
  logic [USED_W-1:0]  used;

  stamp_t      stamp_q[$];
  stamp_t      want;
  logic [7:0]  text_q[$];
  int          errors;
  int          live_chars;
  int          quiet_cycles;
  int          burst_left;
  bit          bursty;
  bit          hold_results;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] acc_dec(logic [63:0] acc, logic [3:0] d, logic [63:0] cap);
    logic [63:0] n;
    n = acc * 64'd10 + d;
    if (acc > cap || n > cap) return cap;
    return n;
  endfunction

  function automatic void clear_parse();
    ph   = P_IDLE;
    ndig = '0;
    grp1 = '0;
    grp2 = '0;
    grp3 = '0;
    frac = '0;
    hrs  = 1'b0;
    used = '0;
  endfunction

  function automatic void bump_used();
    if (used != 8'hff) used = used + 8'd1;
  endfunction

  function automatic void bump_digits();
    if (ndig != 8'hff) ndig = ndig + 8'd1;
  endfunction

  function automatic void open_group(parse_phase_t nxt);
    ndig = 8'd1;
    bump_used();
    ph = nxt;
  endfunction

  function automatic void post_stamp(logic ok, logic [63:0] ms);
    stamp_t r;
    r.ok   = ok;
    r.ms   = ok ? ms[TIME_W-1:0] : '0;
    r.used = used;
    stamp_q.push_back(r);
    ph = P_IDLE;
  endfunction

  function automatic void judge_fraction();
    logic [63:0] h, m, s;
    if (hrs) begin
      h = grp1; m = grp2; s = grp3;
    end else begin
      h = '0; m = grp1; s = grp2;
    end
    if (ndig != 8'd3 || m > 59 || s > 59) post_stamp(1'b0, '0);
    else post_stamp(1'b1, h * MS_PER_HOUR + m * MS_PER_MIN + s * MS_PER_SEC + frac);
  endfunction

  function automatic void predict_stamp(logic st, logic [7:0] c, logic lst);
    logic        dig;
    logic [3:0]  d;
    logic [63:0] hcap;
    dig  = (c >= CH_0) && (c <= CH_9);
    d    = dig ? 4'(c - CH_0) : 4'd0;
    hcap = (64'd1 << HOURS_W) - 64'd1;
    if (st) begin
      clear_parse();
      if (!dig) post_stamp(1'b0, '0);
      else begin
        grp1 = HOURS_W'(d);
        open_group(P_G1);
      end
    end else begin
      case (ph)
        P_G1: begin
          if (dig) begin
            grp1 = HOURS_W'(acc_dec(grp1, d, hcap));
            bump_digits();
            bump_used();
          end else begin
            hrs = (ndig != 8'd2) || (grp1 > 59);
            bump_used();
            if (c != CH_COLON) post_stamp(1'b0, '0);
            else ph = P_G2_LEAD;
          end
        end
        P_G2_LEAD: begin
          if (!dig) post_stamp(1'b0, '0);
          else begin
            grp2 = 7'(d);
            open_group(P_G2);
          end
        end
        P_G2: begin
          if (dig) begin
            grp2 = 7'(acc_dec(grp2, d, 64'd127));
            bump_digits();
            bump_used();
          end else if (ndig != 8'd2) begin
            post_stamp(1'b0, '0);
          end else begin
            bump_used();
            // a colon after the second group forces hours
            if (c == CH_COLON) begin
              hrs = 1'b1;
              ph  = P_G3_LEAD;
            end else if (!hrs && c == CH_DOT) begin
              ph = P_FR_LEAD;
            end else begin
              post_stamp(1'b0, '0);
            end
          end
        end
        P_G3_LEAD: begin
          if (!dig) post_stamp(1'b0, '0);
          else begin
            grp3 = 7'(d);
            open_group(P_G3);
          end
        end
        P_G3: begin
          if (dig) begin
            grp3 = 7'(acc_dec(grp3, d, 64'd127));
            bump_digits();
            bump_used();
          end else if (ndig != 8'd2) begin
            post_stamp(1'b0, '0);
          end else begin
            bump_used();
            if (c != CH_DOT) post_stamp(1'b0, '0);
            else ph = P_FR_LEAD;
          end
        end
        P_FR_LEAD: begin
          if (!dig) post_stamp(1'b0, '0);
          else begin
            frac = FRAC_W'(d);
            open_group(P_FR);
          end
        end
        P_FR: begin
          // terminator of the fraction is not consumed
          if (!dig) judge_fraction();
          else begin
            frac = FRAC_W'(acc_dec(frac, d, 64'd1023));
            bump_digits();
            bump_used();
          end
        end
        default: ;
      endcase
    end
    if (lst && ph != P_IDLE) begin
      if (ph == P_FR) judge_fraction();
      else post_stamp(1'b0, '0);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_char(input logic st, input logic [7:0] c, input logic lst);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    char_if.valid     <= 1'b1;
    char_if.start_req <= st;
    char_if.ch        <= c;
    char_if.last      <= lst;
    do @(posedge clk); while (!char_if.ready);
    if (st || ph != P_IDLE) live_chars++;
    predict_stamp(st, c, lst);
  endtask

  task automatic send_text(input string s, input bit end_mark);
    for (int i = 0; i < s.len(); i++)
      send_char(i == 0, s[i], end_mark && (i == s.len() - 1));
  endtask

  task automatic send_seq(input bit end_mark);
    for (int i = 0; i < text_q.size(); i++)
      send_char(i == 0, text_q[i], end_mark && (i == text_q.size() - 1));
  endtask

  // sender stops and waits until every expected result has come out
  task automatic settle();
    char_if.valid <= 1'b0;
    while (stamp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- text builders

  function automatic int pick_len(int usual);
    if ($urandom_range(0, 7) != 0) return usual;
    return $urandom_range(0, usual + 2);
  endfunction

  function automatic void push_field(int nd);
    int v;
    if (nd == 2) begin
      v = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
      text_q.push_back(CH_0 + 8'(v / 10));
      text_q.push_back(CH_0 + 8'(v % 10));
    end else begin
      repeat (nd) text_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0:       return CH_COLON;
      1:       return CH_DOT;
      2:       return CH_0 + 8'($urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_stamp(bit mutate);
    int pos;
    text_q.delete();
    if ($urandom_range(0, 1)) begin
      push_field(($urandom_range(0, 5) == 0) ? $urandom_range(3, 9) : $urandom_range(1, 2));
      text_q.push_back(CH_COLON);
    end
    push_field(pick_len(2));
    text_q.push_back(CH_COLON);
    push_field(pick_len(2));
    text_q.push_back(CH_DOT);
    push_field(pick_len(3));
    if (mutate && text_q.size() > 1) begin
      pos = $urandom_range(0, text_q.size() - 1);
      if ($urandom_range(0, 3) == 0) text_q.delete(pos);
      else text_q[pos] = pick_byte();
    end
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_text("00:00.000", 1);
    send_text("59:59.999", 1);
    send_text("1048575:59:59.999", 1);
    send_text("60:00:00.000", 1);
    send_text("60:00.000", 1);          // hours without a third group
    send_text("01:02:03.004", 1);
    send_text("12:34.5678", 1);         // four fraction digits
    send_text("12:34.567 ", 0);         // fraction closed by a space
    send_text("12:60.000", 1);
    send_text("12:3.", 0);              // short group
    send_text("12x", 0);                // wrong separator
    send_text("12::", 0);               // missing digit
    send_text(":", 0);
    send_char(0, "a", 1);               // no parse open: ignored
    send_text("12:3", 0);
    send_text("00:01.002", 1);          // restart drops the open parse
    send_text("12:34", 1);              // text ends mid parse
    send_char(1, 8'hff, 0);
    send_text("12:3", 0);
    send_char(0, 8'h00, 0);
  endtask

  task automatic test_saturation();
    // hours accumulator and consumed count both run into their limits
    send_char(1, "9", 0);
    repeat (270) send_char(0, "9", 0);
    send_text(":00:00.000", 0);
    send_char(0, CH_SPACE, 1);
    send_text("12:", 0);
    repeat (6) send_char(0, "9", 0);
    send_text(":00.000", 1);
  endtask

  task automatic test_random_stamps();
    int base;
    int n;
    base = live_chars;
    while (live_chars - base < RANDOM_CHARS) begin
      if ($urandom_range(0, 15) == 0) bursty = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_char($urandom_range(0, 3) == 0, pick_byte(), $urandom_range(0, 5) == 0);
      end else begin
        build_stamp($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 3))
          0: send_seq(1);
          1: begin
            send_seq(0);
            send_char(0, pick_byte(), 0);
            n = $urandom_range(0, 3);
            repeat (n) send_char(0, pick_byte(), $urandom_range(0, 1));
          end
          2: send_seq(0);
          default: begin
            send_seq(0);
            send_char(0, CH_SPACE, $urandom_range(0, 1));
          end
        endcase
      end
    end
    bursty = 1'b1;
  endtask

  task automatic test_result_backpressure();
    bursty       = 1'b0;
    hold_results = 1'b1;
    repeat (12) begin
      build_stamp(0);
      send_seq(1);
    end
    bursty = 1'b1;
    settle();
  endtask

  task automatic test_pause_between();
    repeat (4) begin
      build_stamp(0);
      send_seq(1);
      settle();
    end
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    int mode;
    int left;
    mode = 0;
    left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 4);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 3) != 0);
        2:       res_if.ready <= $urandom_range(0, 1);
        3:       res_if.ready <= ((left % 7) > 2);
        default: res_if.ready <= ((left % 29) < 20);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (stamp_q.size() == 0) begin
        $display("%0t: unexpected result valid_res=%0b time_ms=%0d chars_used=%0d",
                 $time, res_if.valid_res, res_if.time_ms, res_if.chars_used);
        errors++;
      end else begin
        want = stamp_q.pop_front();
        if (res_if.valid_res !== want.ok) begin
          $display("%0t: valid_res expected %0b got %0b", $time, want.ok, res_if.valid_res);
          errors++;
        end
        if (res_if.time_ms !== want.ms) begin
          $display("%0t: time_ms expected %0d got %0d", $time, want.ms, res_if.time_ms);
          errors++;
        end
        if (res_if.chars_used !== want.used) begin
          $display("%0t: chars_used expected %0d got %0d", $time, want.used,
                   res_if.chars_used);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL webvtt_timestamp_parser");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    errors            = 0;
    live_chars        = 0;
    quiet_cycles      = 0;
    burst_left        = 0;
    bursty            = 1'b1;
    hold_results      = 1'b0;
    char_if.valid     = 1'b0;
    char_if.start_req = 1'b0;
    char_if.ch        = '0;
    char_if.last      = 1'b0;
    clear_parse();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_random_stamps();
    test_result_backpressure();
    test_pause_between();
    settle();
    if (errors == 0)
      $display("PASS webvtt_timestamp_parser");
    else
      $display("FAIL webvtt_timestamp_parser");
    $finish;
  end

endmodule
